// ----- design/amgd_pkg.sv -----
// Shared codes and limits for the adjacency-matrix graph store with depth-first walk.
// No dependencies; used by the top level, the checker and the testbench.
package amgd_pkg;

    localparam logic [2:0] ACT_ADD_EDGE   = 3'd0;
    localparam logic [2:0] ACT_QUERY_EDGE = 3'd1;
    localparam logic [2:0] ACT_QUERY_NODE = 3'd2;
    localparam logic [2:0] ACT_START_WALK = 3'd3;
    localparam logic [2:0] ACT_WALK_STEP  = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_INDEX = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;

    localparam logic [0:0] CFG_DIRECTED   = 1'd0;
    localparam logic [0:0] CFG_NODE_COUNT = 1'd1;

    localparam logic [31:0] ABSENT_WEIGHT = 32'h7F7F_FFFF;
    localparam logic [15:0] DEG_MAX       = 16'hFFFF;
    localparam logic [12:0] EDGE_CNT_MAX  = 13'h1FFF;

    typedef enum logic [11:0] {
        S_CLEAR  = 12'b0000_0000_0001,
        S_IDLE   = 12'b0000_0000_0010,
        S_ADD_RD = 12'b0000_0000_0100,
        S_ADD_WR = 12'b0000_0000_1000,
        S_MIR_RD = 12'b0000_0001_0000,
        S_MIR_WR = 12'b0000_0010_0000,
        S_QUERY  = 12'b0000_0100_0000,
        S_POP    = 12'b0000_1000_0000,
        S_SCAN   = 12'b0001_0000_0000,
        S_CHECK  = 12'b0010_0000_0000,
        S_FETCH  = 12'b0100_0000_0000,
        S_DONE   = 12'b1000_0000_0000
    } t_state;

    function automatic logic [15:0] sat_inc16(input logic [15:0] v);
        return (v == DEG_MAX) ? v : v + 16'd1;
    endfunction

endpackage

// ----- design/amgd_ram.sv -----
// Simple dual-port synchronous RAM: one write port, one read port, registered read data.
// No dependencies; instantiated by the graph store top level.
module amgd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // hold read data until the next read
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/adjacency_matrix_graph_dfs.sv -----
// Top level of the adjacency-matrix graph store with depth-first walk.
// Depends on amgd_pkg and amgd_ram (weight matrix, walk stack, degree counters).
//
// One transaction in, one result out. After reset the block sweeps the weight matrix to the
// "no edge" pattern, one entry a cycle, all MAX_NODES*MAX_NODES entries (4096 at the defaults),
// with s_axis_tready low; configuration writes are taken during the sweep. A walk step's
// neighbor scan reads one matrix row through the single read port of the weight memory,
// one entry a cycle. A new transaction is accepted as soon as the previous one has moved
// its result into the output register, even if that result has not been taken yet.
module adjacency_matrix_graph_dfs #(
    parameter int MAX_NODES   = 64,
    parameter int STACK_DEPTH = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [6:0]  i_cfg_data,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // tdata: first_node[5:0], second_node[11:6], edge_weight[43:12], zero fill [47:44]
    input  logic [47:0] i_s_axis_tdata,
    // tuser: action[2:0]
    input  logic [2:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // tdata: weight_out[31:0], adjacent[32], out_degree[48:33], in_degree[64:49],
    //        isolated[65], visit_node[71:66], walk_more[72], edge_total[85:73], zero [87:86]
    output logic [87:0] o_m_axis_tdata,
    // tuser: status[1:0]
    output logic [1:0]  o_m_axis_tuser
);

    localparam int IW  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int AW  = $clog2(MAX_NODES * MAX_NODES);
    localparam int NCW = $clog2(MAX_NODES + 1);
    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int SDW = $clog2(STACK_DEPTH + 1);
    localparam logic [AW-1:0]  CLR_LAST  = AW'(MAX_NODES * MAX_NODES - 1);
    localparam logic [SDW-1:0] STACK_MAX = SDW'(STACK_DEPTH);

    // configuration
    logic       r_directed;
    logic [6:0] r_node_count;

    // control
    amgd_pkg::t_state r_state, n_state;
    logic [AW-1:0]    r_clr, n_clr;
    logic [2:0]       r_act, n_act;
    logic [1:0]       r_status, n_status;
    logic [IW-1:0]    r_a, n_a, r_b, n_b;
    logic [31:0]      r_w, n_w;
    logic             r_odv, n_odv, r_idv, n_idv;
    logic [12:0]      r_edges, n_edges;
    logic [MAX_NODES-1:0] r_visited, n_visited;
    logic [MAX_NODES-1:0] r_iso, n_iso;
    logic [MAX_NODES-1:0] r_od_vld, n_od_vld, r_id_vld, n_id_vld;
    logic [SDW-1:0]   r_depth, n_depth;
    logic [IW-1:0]    r_top, n_top;
    logic             r_top_ok, n_top_ok;
    logic [IW-1:0]    r_scan, n_scan;
    logic [NCW-1:0]   r_j, n_j;
    logic [IW-1:0]    r_pj, n_pj;
    logic             r_pv, n_pv;

    // output register
    logic        r_ovalid, n_ovalid;
    logic [1:0]  r_o_status, n_o_status;
    logic [31:0] r_o_wout, n_o_wout;
    logic        r_o_adj, n_o_adj;
    logic [15:0] r_o_od, n_o_od, r_o_id, n_o_id;
    logic        r_o_iso, n_o_iso;
    logic [5:0]  r_o_vis, n_o_vis;
    logic        r_o_more, n_o_more;
    logic [12:0] r_o_edges, n_o_edges;

    // memory ports
    logic          w_we, w_re;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [31:0]   w_wdata, w_rdata;
    logic          s_we, s_re;
    logic [SAW-1:0] s_waddr, s_raddr;
    logic [IW-1:0] s_wdata, s_rdata;
    logic          od_we, od_re, id_we, id_re;
    logic [IW-1:0] od_waddr, od_raddr, id_waddr, id_raddr;
    logic [15:0]   od_wdata, od_rdata, id_wdata, id_rdata;

    // input fields and range checks
    logic [5:0]  in_first, in_second;
    logic [31:0] in_weight;
    logic [2:0]  in_action;
    logic [15:0] eff_n;
    logic        a_bad, b_bad, accept, out_free;
    logic [15:0] od_cur, id_cur;
    logic [15:0] vis16;

    assign in_first  = i_s_axis_tdata[5:0];
    assign in_second = i_s_axis_tdata[11:6];
    assign in_weight = i_s_axis_tdata[43:12];
    assign in_action = i_s_axis_tuser;

    // cap node_count at the memory size
    assign eff_n = ({9'd0, r_node_count} > 16'(MAX_NODES)) ? 16'(MAX_NODES)
                                                           : {9'd0, r_node_count};
    assign a_bad = {10'd0, in_first}  >= eff_n;
    assign b_bad = {10'd0, in_second} >= eff_n;

    assign o_s_axis_tready = (r_state == amgd_pkg::S_IDLE);
    assign accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_ovalid || i_m_axis_tready;

    assign od_cur = r_odv ? od_rdata : 16'd0;
    assign id_cur = r_idv ? id_rdata : 16'd0;
    assign vis16  = 16'(n_top);

    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_act     = r_act;
        n_status  = r_status;
        n_a       = r_a;
        n_b       = r_b;
        n_w       = r_w;
        n_odv     = r_odv;
        n_idv     = r_idv;
        n_edges   = r_edges;
        n_visited = r_visited;
        n_iso     = r_iso;
        n_od_vld  = r_od_vld;
        n_id_vld  = r_id_vld;
        n_depth   = r_depth;
        n_top     = r_top;
        n_top_ok  = r_top_ok;
        n_scan    = r_scan;
        n_j       = r_j;
        n_pj      = r_pj;
        n_pv      = r_pv;

        n_ovalid   = r_ovalid && !i_m_axis_tready;
        n_o_status = r_o_status;
        n_o_wout   = r_o_wout;
        n_o_adj    = r_o_adj;
        n_o_od     = r_o_od;
        n_o_id     = r_o_id;
        n_o_iso    = r_o_iso;
        n_o_vis    = r_o_vis;
        n_o_more   = r_o_more;
        n_o_edges  = r_o_edges;

        w_we = 1'b0; w_waddr = '0; w_wdata = amgd_pkg::ABSENT_WEIGHT;
        w_re = 1'b0; w_raddr = '0;
        s_we = 1'b0; s_waddr = '0; s_wdata = '0;
        s_re = 1'b0; s_raddr = '0;
        od_we = 1'b0; od_waddr = '0; od_wdata = '0; od_re = 1'b0; od_raddr = '0;
        id_we = 1'b0; id_waddr = '0; id_wdata = '0; id_re = 1'b0; id_raddr = '0;

        case (r_state)
            amgd_pkg::S_CLEAR: begin
                // sweep every matrix entry to "no edge"
                w_we    = 1'b1;
                w_waddr = r_clr;
                n_clr   = r_clr + AW'(1);
                if (r_clr == CLR_LAST) begin
                    n_state = amgd_pkg::S_IDLE;
                end
            end
            amgd_pkg::S_IDLE: begin
                if (accept) begin
                    n_act    = in_action;
                    n_a      = IW'({10'd0, in_first});
                    n_b      = IW'({10'd0, in_second});
                    n_w      = in_weight;
                    n_status = amgd_pkg::ST_OK;
                    n_state  = amgd_pkg::S_DONE;
                    if (in_action <= amgd_pkg::ACT_START_WALK && (a_bad ||
                        ((in_action == amgd_pkg::ACT_ADD_EDGE ||
                          in_action == amgd_pkg::ACT_QUERY_EDGE) && b_bad))) begin
                        n_status = amgd_pkg::ST_BAD_INDEX;
                    end else begin
                        case (in_action)
                            amgd_pkg::ACT_ADD_EDGE: n_state = amgd_pkg::S_ADD_RD;
                            amgd_pkg::ACT_QUERY_EDGE,
                            amgd_pkg::ACT_QUERY_NODE: n_state = amgd_pkg::S_QUERY;
                            amgd_pkg::ACT_START_WALK: begin
                                // fresh walk: stack holds only the source
                                n_visited = '0;
                                s_we      = 1'b1;
                                s_waddr   = '0;
                                s_wdata   = IW'({10'd0, in_first});
                                n_depth   = SDW'(1);
                                n_top     = IW'({10'd0, in_first});
                                n_top_ok  = 1'b1;
                            end
                            amgd_pkg::ACT_WALK_STEP: begin
                                if (r_depth == '0) begin
                                    n_status = amgd_pkg::ST_EMPTY;
                                end else begin
                                    n_state = amgd_pkg::S_POP;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            end
            amgd_pkg::S_ADD_RD: begin
                w_re     = 1'b1;
                w_raddr  = AW'(32'(r_a) * 32'(MAX_NODES) + 32'(r_b));
                od_re    = 1'b1;
                od_raddr = r_a;
                id_re    = 1'b1;
                id_raddr = r_b;
                n_odv    = r_od_vld[r_a];
                n_idv    = r_id_vld[r_b];
                n_state  = amgd_pkg::S_ADD_WR;
            end
            amgd_pkg::S_ADD_WR: begin
                if (w_rdata == amgd_pkg::ABSENT_WEIGHT && r_edges < amgd_pkg::EDGE_CNT_MAX) begin
                    n_edges = r_edges + 13'd1;
                end
                w_we     = 1'b1;
                w_waddr  = AW'(32'(r_a) * 32'(MAX_NODES) + 32'(r_b));
                w_wdata  = r_w;
                od_we    = 1'b1;
                od_waddr = r_a;
                od_wdata = amgd_pkg::sat_inc16(od_cur);
                id_we    = 1'b1;
                id_waddr = r_b;
                id_wdata = amgd_pkg::sat_inc16(id_cur);
                n_od_vld[r_a] = 1'b1;
                n_id_vld[r_b] = 1'b1;
                n_iso[r_a]    = 1'b0;
                n_iso[r_b]    = 1'b0;
                n_state = r_directed ? amgd_pkg::S_DONE : amgd_pkg::S_MIR_RD;
            end
            amgd_pkg::S_MIR_RD: begin
                // writes of the previous cycle are in memory, so a self loop reads them back
                w_we     = 1'b1;
                w_waddr  = AW'(32'(r_b) * 32'(MAX_NODES) + 32'(r_a));
                w_wdata  = r_w;
                od_re    = 1'b1;
                od_raddr = r_b;
                id_re    = 1'b1;
                id_raddr = r_a;
                n_odv    = r_od_vld[r_b];
                n_idv    = r_id_vld[r_a];
                n_state  = amgd_pkg::S_MIR_WR;
            end
            amgd_pkg::S_MIR_WR: begin
                od_we    = 1'b1;
                od_waddr = r_b;
                od_wdata = amgd_pkg::sat_inc16(od_cur);
                id_we    = 1'b1;
                id_waddr = r_a;
                id_wdata = amgd_pkg::sat_inc16(id_cur);
                n_od_vld[r_b] = 1'b1;
                n_id_vld[r_a] = 1'b1;
                n_state  = amgd_pkg::S_DONE;
            end
            amgd_pkg::S_QUERY: begin
                w_re     = 1'b1;
                w_raddr  = AW'(32'(r_a) * 32'(MAX_NODES) + 32'(r_b));
                od_re    = 1'b1;
                od_raddr = r_a;
                id_re    = 1'b1;
                id_raddr = r_a;
                n_odv    = r_od_vld[r_a];
                n_idv    = r_id_vld[r_a];
                n_state  = amgd_pkg::S_DONE;
            end
            amgd_pkg::S_POP: begin
                n_depth  = r_depth - SDW'(1);
                n_top_ok = 1'b0;
                if (r_visited[r_top]) begin
                    n_state = amgd_pkg::S_CHECK;
                end else begin
                    n_visited[r_top] = 1'b1;
                    n_scan  = r_top;
                    n_j     = '0;
                    n_pv    = 1'b0;
                    n_state = amgd_pkg::S_SCAN;
                end
            end
            amgd_pkg::S_SCAN: begin
                // issue one row read a cycle, judge the entry read last cycle
                if (16'(r_j) < eff_n) begin
                    w_re    = 1'b1;
                    w_raddr = AW'(32'(r_scan) * 32'(MAX_NODES) + 32'(r_j));
                    n_pj    = IW'(r_j);
                    n_pv    = 1'b1;
                    n_j     = r_j + NCW'(1);
                end else begin
                    n_pv = 1'b0;
                    if (!r_pv) begin
                        n_state = amgd_pkg::S_CHECK;
                    end
                end
                if (r_pv && w_rdata != amgd_pkg::ABSENT_WEIGHT && !r_visited[r_pj] &&
                    r_depth < STACK_MAX) begin
                    s_we     = 1'b1;
                    s_waddr  = r_depth[SAW-1:0];
                    s_wdata  = r_pj;
                    n_depth  = r_depth + SDW'(1);
                    n_top    = r_pj;
                    n_top_ok = 1'b1;
                end
            end
            amgd_pkg::S_CHECK: begin
                // drop visited tops until an unvisited one or an empty stack
                if (r_depth == '0) begin
                    n_state = amgd_pkg::S_DONE;
                end else if (r_top_ok) begin
                    n_state = r_visited[r_top] ? amgd_pkg::S_POP : amgd_pkg::S_DONE;
                end else begin
                    s_re    = 1'b1;
                    s_raddr = SAW'(r_depth - SDW'(1));
                    n_state = amgd_pkg::S_FETCH;
                end
            end
            amgd_pkg::S_FETCH: begin
                n_top    = s_rdata;
                n_top_ok = 1'b1;
                n_state  = amgd_pkg::S_CHECK;
            end
            amgd_pkg::S_DONE: begin
                if (out_free) begin
                    n_ovalid   = 1'b1;
                    n_o_status = r_status;
                    n_o_wout   = '0;
                    n_o_adj    = 1'b0;
                    n_o_od     = '0;
                    n_o_id     = '0;
                    n_o_iso    = 1'b0;
                    if (r_status == amgd_pkg::ST_OK) begin
                        case (r_act)
                            amgd_pkg::ACT_ADD_EDGE: begin
                                n_o_wout = r_w;
                                n_o_adj  = (r_w != amgd_pkg::ABSENT_WEIGHT);
                            end
                            amgd_pkg::ACT_QUERY_EDGE: begin
                                n_o_wout = w_rdata;
                                n_o_adj  = (w_rdata != amgd_pkg::ABSENT_WEIGHT);
                            end
                            amgd_pkg::ACT_QUERY_NODE: begin
                                n_o_od  = od_cur;
                                n_o_id  = id_cur;
                                n_o_iso = r_iso[r_a];
                            end
                            default: ;
                        endcase
                    end
                    n_o_vis   = (r_depth != '0) ? vis16[5:0] : 6'd0;
                    n_o_more  = (r_depth != '0);
                    n_o_edges = n_edges;
                    n_state   = amgd_pkg::S_IDLE;
                end
            end
            default: n_state = amgd_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_directed   <= 1'b0;
            r_node_count <= 7'd64;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                amgd_pkg::CFG_DIRECTED:   r_directed   <= i_cfg_data[0];
                amgd_pkg::CFG_NODE_COUNT: r_node_count <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= amgd_pkg::S_CLEAR;
            r_clr     <= '0;
            r_edges   <= '0;
            r_visited <= '0;
            r_iso     <= '1;
            r_od_vld  <= '0;
            r_id_vld  <= '0;
            r_depth   <= '0;
            r_top_ok  <= 1'b0;
            r_pv      <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_edges   <= n_edges;
            r_visited <= n_visited;
            r_iso     <= n_iso;
            r_od_vld  <= n_od_vld;
            r_id_vld  <= n_id_vld;
            r_depth   <= n_depth;
            r_top_ok  <= n_top_ok;
            r_pv      <= n_pv;
            r_ovalid  <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act      <= n_act;
        r_status   <= n_status;
        r_a        <= n_a;
        r_b        <= n_b;
        r_w        <= n_w;
        r_odv      <= n_odv;
        r_idv      <= n_idv;
        r_top      <= n_top;
        r_scan     <= n_scan;
        r_j        <= n_j;
        r_pj       <= n_pj;
        r_o_status <= n_o_status;
        r_o_wout   <= n_o_wout;
        r_o_adj    <= n_o_adj;
        r_o_od     <= n_o_od;
        r_o_id     <= n_o_id;
        r_o_iso    <= n_o_iso;
        r_o_vis    <= n_o_vis;
        r_o_more   <= n_o_more;
        r_o_edges  <= n_o_edges;
    end

    amgd_ram #(.WIDTH(32), .DEPTH(MAX_NODES * MAX_NODES)) u_weight (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_re(w_re), .i_raddr(w_raddr), .o_rdata(w_rdata)
    );

    amgd_ram #(.WIDTH(IW), .DEPTH(STACK_DEPTH)) u_stack (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(s_waddr), .i_wdata(s_wdata),
        .i_re(s_re), .i_raddr(s_raddr), .o_rdata(s_rdata)
    );

    amgd_ram #(.WIDTH(16), .DEPTH(MAX_NODES)) u_out_deg (
        .i_clk(i_clk), .i_we(od_we), .i_waddr(od_waddr), .i_wdata(od_wdata),
        .i_re(od_re), .i_raddr(od_raddr), .o_rdata(od_rdata)
    );

    amgd_ram #(.WIDTH(16), .DEPTH(MAX_NODES)) u_in_deg (
        .i_clk(i_clk), .i_we(id_we), .i_waddr(id_waddr), .i_wdata(id_wdata),
        .i_re(id_re), .i_raddr(id_raddr), .o_rdata(id_rdata)
    );

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tuser  = r_o_status;
    assign o_m_axis_tdata  = {2'b00, r_o_edges, r_o_more, r_o_vis, r_o_iso,
                              r_o_id, r_o_od, r_o_adj, r_o_wout};

endmodule

// ----- design/amgd_checker.sv -----
// Port-level checks for the graph store with depth-first walk, bound to the top level.
// Depends on amgd_pkg and adjacency_matrix_graph_dfs.
module amgd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [87:0] o_m_axis_tdata,
    input logic [1:0]  o_m_axis_tuser
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result changed");

    a_reset_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_s_axis_tready)
        else $error("ready right after reset, clearing sweep skipped");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("second transaction taken while one is at work");

    a_empty_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser == amgd_pkg::ST_EMPTY
        |-> !o_m_axis_tdata[72] && o_m_axis_tdata[71:66] == 6'd0)
        else $error("empty-stack result reports a pending walk");

    a_adjacent_weight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[32]
        |-> o_m_axis_tdata[31:0] != amgd_pkg::ABSENT_WEIGHT && o_m_axis_tuser == amgd_pkg::ST_OK)
        else $error("adjacent flag with absent weight or error status");

endmodule

bind adjacency_matrix_graph_dfs amgd_checker u_amgd_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .i_s_axis_tvalid(i_s_axis_tvalid),
    .o_s_axis_tready(o_s_axis_tready),
    .o_m_axis_tvalid(o_m_axis_tvalid),
    .i_m_axis_tready(i_m_axis_tready),
    .o_m_axis_tdata(o_m_axis_tdata),
    .o_m_axis_tuser(o_m_axis_tuser)
);

// ----- test/tb_adjacency_matrix_graph_dfs.sv -----
// Testbench for adjacency_matrix_graph_dfs: random and directed graph edits, queries and
// depth-first walk steps, checked against a behavioral graph model in a scoreboard class.
// Depends on amgd_pkg and the RTL of the block.
module tb_adjacency_matrix_graph_dfs;
    timeunit 1ns;
    timeprecision 1ps;

    // packed in port order: tuser on top, then tdata from its highest field down
    typedef struct packed {
        logic [1:0]  status;
        logic [12:0] edge_total;
        logic        walk_more;
        logic [5:0]  visit_node;
        logic        isolated;
        logic [15:0] in_degree;
        logic [15:0] out_degree;
        logic        adjacent;
        logic [31:0] weight_out;
    } t_graph_result;

    // Behavioral graph: holds the matrix, counters and walk state, and a queue of expected
    // results in acceptance order.
    class t_graph_scoreboard;
        logic [31:0]   weights [64*64];
        bit            lonely [64];
        logic [15:0]   outdeg [64];
        logic [15:0]   indeg [64];
        logic [12:0]   edges;
        bit            seen [64];
        logic [5:0]    dfs_stack [$];
        bit            oriented;
        logic [6:0]    nodes;
        t_graph_result pending [$];
        int            errors;

        function void clear_all();
            foreach (weights[i]) weights[i] = amgd_pkg::ABSENT_WEIGHT;
            for (int i = 0; i < 64; i++) begin
                lonely[i] = 1; outdeg[i] = 0; indeg[i] = 0; seen[i] = 0;
            end
            edges = 0; dfs_stack.delete(); oriented = 0; nodes = 64;
            pending.delete(); errors = 0;
        endfunction

        function void set_reg(logic idx, logic [6:0] val);
            if (idx == amgd_pkg::CFG_DIRECTED) oriented = val[0];
            else nodes = val;
        endfunction

        function void note_input(logic [2:0] act, logic [5:0] a, logic [5:0] b,
                                 logic [31:0] w);
            t_graph_result r;
            int n;
            logic [5:0] top;
            r = '0;
            n = (nodes > 64) ? 64 : nodes;
            if (act <= amgd_pkg::ACT_START_WALK && (a >= n ||
                    ((act == amgd_pkg::ACT_ADD_EDGE || act == amgd_pkg::ACT_QUERY_EDGE)
                     && b >= n))) begin
                r.status = amgd_pkg::ST_BAD_INDEX;
            end else if (act == amgd_pkg::ACT_ADD_EDGE) begin
                if (weights[a*64+b] == amgd_pkg::ABSENT_WEIGHT &&
                    edges < amgd_pkg::EDGE_CNT_MAX) edges++;
                weights[a*64+b] = w;
                if (!oriented) weights[b*64+a] = w;
                lonely[a] = 0; lonely[b] = 0;
                if (outdeg[a] != amgd_pkg::DEG_MAX) outdeg[a]++;
                if (indeg[b] != amgd_pkg::DEG_MAX) indeg[b]++;
                if (!oriented) begin
                    if (outdeg[b] != amgd_pkg::DEG_MAX) outdeg[b]++;
                    if (indeg[a] != amgd_pkg::DEG_MAX) indeg[a]++;
                end
                r.weight_out = weights[a*64+b];
                r.adjacent = r.weight_out != amgd_pkg::ABSENT_WEIGHT;
            end else if (act == amgd_pkg::ACT_QUERY_EDGE) begin
                r.weight_out = weights[a*64+b];
                r.adjacent = r.weight_out != amgd_pkg::ABSENT_WEIGHT;
            end else if (act == amgd_pkg::ACT_QUERY_NODE) begin
                r.out_degree = outdeg[a]; r.in_degree = indeg[a]; r.isolated = lonely[a];
            end else if (act == amgd_pkg::ACT_START_WALK) begin
                foreach (seen[i]) seen[i] = 0;
                dfs_stack.delete();
                dfs_stack = {dfs_stack, a};
            end else if (act == amgd_pkg::ACT_WALK_STEP) begin
                if (dfs_stack.size() == 0) r.status = amgd_pkg::ST_EMPTY;
                else begin
                    do begin
                        top = dfs_stack.pop_back();
                        if (!seen[top]) begin
                            seen[top] = 1;
                            for (int j = 0; j < n; j++)
                                if (weights[top*64+j] != amgd_pkg::ABSENT_WEIGHT && !seen[j]
                                        && dfs_stack.size() < 4096)
                                    dfs_stack = {dfs_stack, 6'(j)};
                        end
                    end while (dfs_stack.size() != 0 && seen[dfs_stack[$]]);
                end
            end
            // unknown actions change nothing
            r.visit_node = dfs_stack.size() ? dfs_stack[$] : 6'd0;
            r.walk_more = dfs_stack.size() != 0;
            r.edge_total = edges;
            pending = {pending, r};
        endfunction

        function void check_result(t_graph_result got);
            t_graph_result e;
            if (pending.size() == 0) begin
                $error("result with nothing expected: %h", got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.status !== e.status) begin
                $error("status exp %0d got %0d", e.status, got.status); errors++;
            end
            if (got.weight_out !== e.weight_out) begin
                $error("weight_out exp %h got %h", e.weight_out, got.weight_out); errors++;
            end
            if (got.adjacent !== e.adjacent) begin
                $error("adjacent exp %0d got %0d", e.adjacent, got.adjacent); errors++;
            end
            if (got.out_degree !== e.out_degree) begin
                $error("out_degree exp %0d got %0d", e.out_degree, got.out_degree); errors++;
            end
            if (got.in_degree !== e.in_degree) begin
                $error("in_degree exp %0d got %0d", e.in_degree, got.in_degree); errors++;
            end
            if (got.isolated !== e.isolated) begin
                $error("isolated exp %0d got %0d", e.isolated, got.isolated); errors++;
            end
            if (got.visit_node !== e.visit_node) begin
                $error("visit_node exp %0d got %0d", e.visit_node, got.visit_node); errors++;
            end
            if (got.walk_more !== e.walk_more) begin
                $error("walk_more exp %0d got %0d", e.walk_more, got.walk_more); errors++;
            end
            if (got.edge_total !== e.edge_total) begin
                $error("edge_total exp %0d got %0d", e.edge_total, got.edge_total); errors++;
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_we = 0;
    logic [0:0]  i_cfg_idx = '0;
    logic [6:0]  i_cfg_data = '0;
    logic        i_s_axis_tvalid = 0;
    logic        o_s_axis_tready;
    logic [47:0] i_s_axis_tdata = '0;
    logic [2:0]  i_s_axis_tuser = '0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 0;
    logic [87:0] o_m_axis_tdata;
    logic [1:0]  o_m_axis_tuser;

    t_graph_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_off = 0;     // cycles the receiver must still stall for the pressure test

    adjacency_matrix_graph_dfs DUT (.*);

    always #1 i_clk = ~i_clk;

    // Receiver: randomly drop tready; check every accepted result.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready)
                sb.check_result({o_m_axis_tuser, o_m_axis_tdata[85:0]});
            if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                i_m_axis_tready <= 0;
            end else begin
                i_m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Offer one item, wait for its acceptance, then note it in the scoreboard.
    // tvalid stays high after acceptance so that the next item can follow at once.
    task automatic send_item(logic [2:0] act, logic [5:0] a, logic [5:0] b, logic [31:0] w);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1;
        i_s_axis_tuser <= act;
        i_s_axis_tdata <= {4'b0, w, b, a};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        sb.note_input(act, a, b, w);
    endtask

    // Write a register only once the block has drained; allow a full walk step to finish.
    task automatic write_reg(logic idx, logic [6:0] val);
        i_s_axis_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 0;
        sb.set_reg(idx, val);
    endtask

    function automatic logic [5:0] pick_node(int n);
        // mostly legal nodes, sometimes anything
        if ($urandom_range(9) == 0 || n == 0) return 6'($urandom_range(63));
        return 6'($urandom_range(n - 1));
    endfunction

    // One random item; walks dominate once a graph is built.
    task automatic random_item(int n);
        int sel;
        logic [31:0] w;
        sel = $urandom_range(99);
        w = ($urandom_range(9) == 0) ? amgd_pkg::ABSENT_WEIGHT : $urandom;
        if (sel < 30) send_item(amgd_pkg::ACT_ADD_EDGE, pick_node(n), pick_node(n), w);
        else if (sel < 42)
            send_item(amgd_pkg::ACT_QUERY_EDGE, pick_node(n), pick_node(n), $urandom);
        else if (sel < 52)
            send_item(amgd_pkg::ACT_QUERY_NODE, pick_node(n), 6'($urandom), $urandom);
        else if (sel < 57)
            send_item(amgd_pkg::ACT_START_WALK, pick_node(n), 6'($urandom), $urandom);
        else if (sel < 97)
            send_item(amgd_pkg::ACT_WALK_STEP, 6'($urandom), 6'($urandom), $urandom);
        else send_item(3'($urandom_range(7, 5)), 6'($urandom), 6'($urandom), $urandom);
    endtask

    initial begin
        #20000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        int ncount;
        sb.clear_all();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;

        // Directed part: field extremes, every action, the special cases.
        send_item(amgd_pkg::ACT_WALK_STEP, 6'd0, 6'd0, 32'd0);     // step on empty stack
        send_item(amgd_pkg::ACT_QUERY_NODE, 6'd63, 6'd0, 32'd0);   // untouched node is isolated
        send_item(amgd_pkg::ACT_ADD_EDGE, 6'd0, 6'd63, 32'hFFFF_FFFF);
        send_item(amgd_pkg::ACT_ADD_EDGE, 6'd63, 6'd0, 32'h0000_0000); // mirror already present
        send_item(amgd_pkg::ACT_ADD_EDGE, 6'd5, 6'd5, 32'h3F80_0000);  // undirected self loop
        send_item(amgd_pkg::ACT_ADD_EDGE, 6'd1, 6'd2, amgd_pkg::ABSENT_WEIGHT); // no-edge pattern
        send_item(amgd_pkg::ACT_QUERY_EDGE, 6'd63, 6'd0, 32'd0);
        send_item(amgd_pkg::ACT_QUERY_EDGE, 6'd1, 6'd2, 32'd0);
        send_item(amgd_pkg::ACT_QUERY_NODE, 6'd5, 6'd0, 32'd0);
        send_item(amgd_pkg::ACT_START_WALK, 6'd0, 6'd0, 32'd0);
        repeat (4) send_item(amgd_pkg::ACT_WALK_STEP, 6'd0, 6'd0, 32'd0);
        send_item(3'd5, 6'd63, 6'd63, 32'hFFFF_FFFF);               // unknown actions
        send_item(3'd7, 6'd0, 6'd0, 32'd0);
        write_reg(amgd_pkg::CFG_NODE_COUNT, 7'd1);
        send_item(amgd_pkg::ACT_ADD_EDGE, 6'd0, 6'd1, 32'h1);       // bad index
        send_item(amgd_pkg::ACT_START_WALK, 6'd1, 6'd0, 32'd0);
        send_item(amgd_pkg::ACT_ADD_EDGE, 6'd0, 6'd0, 32'h2);
        write_reg(amgd_pkg::CFG_NODE_COUNT, 7'd0);                  // rejects every node index
        send_item(amgd_pkg::ACT_QUERY_NODE, 6'd0, 6'd0, 32'd0);
        write_reg(amgd_pkg::CFG_NODE_COUNT, 7'd127);                // capped at 64
        send_item(amgd_pkg::ACT_QUERY_EDGE, 6'd63, 6'd63, 32'd0);
        write_reg(amgd_pkg::CFG_DIRECTED, 7'd1);
        send_item(amgd_pkg::ACT_ADD_EDGE, 6'd10, 6'd11, 32'h4000_0000);
        send_item(amgd_pkg::ACT_QUERY_EDGE, 6'd11, 6'd10, 32'd0);

        // Random phases over several settings and idle profiles.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
                default: begin send_idle_pct = 6; recv_stall_pct = 6; end
            endcase
            case (ph)
                0: ncount = 8;
                1: ncount = 64;
                2: ncount = 2;
                3: ncount = 16;
                4: ncount = 1;
                5: ncount = 100;
                default: ncount = $urandom_range(3, 64);
            endcase
            write_reg(amgd_pkg::CFG_DIRECTED, 7'($urandom_range(1)));
            write_reg(amgd_pkg::CFG_NODE_COUNT, 7'(ncount));
            if (ph == 2) hold_off = 400;                     // long receiver hold-off
            for (int k = 0; k < 210; k++) random_item(ncount > 64 ? 64 : ncount);
        end

        i_s_axis_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
